@@ sv/fpx_pkg.sv @@
// Package: constants, status codes and shared types for the framed packet checker.
`timescale 1ns / 1ps
package fpx_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h55;
  localparam logic [7:0] TAIL_FIRST  = 8'h55;
  localparam logic [7:0] TAIL_SECOND = 8'hAA;

  localparam logic [7:0] MAX_LEN_RESET = 8'd252;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register word index, taken from paddr above the byte offset
  localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HEADER   = 2'd1,
    ST_TAIL_LEN = 2'd2,
    ST_CHECK    = 2'd3
  } status_t;

  typedef struct packed {
    logic       valid;
    status_t    code;
    logic [7:0] len;
  } result_t;

endpackage

@@ sv/fpx_core.sv @@
// Frame tracking state and per-byte check logic for the framed packet checker.
`timescale 1ns / 1ps
module fpx_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       frame_byte,
  input  logic             frame_start,
  input  logic [7:0]       max_len,
  output fpx_pkg::result_t res
);
  import fpx_pkg::*;

  logic [8:0] byte_position, byte_position_next;
  logic [7:0] length_seen, length_seen_next;
  logic [7:0] running_xor, running_xor_next;
  logic       checksum_bad, checksum_bad_next;
  logic       tail_bad, tail_bad_next;
  logic       discarding, discarding_next;

  logic [8:0] pos;
  logic [7:0] len;
  logic [7:0] rx;
  logic       cbad;
  logic       tbad;
  logic [8:0] chk_pos;
  logic       tbad_end;

  always_comb begin
    pos      = frame_start ? 9'd0 : byte_position;
    len      = frame_start ? 8'd0 : length_seen;
    rx       = frame_start ? 8'd0 : running_xor;
    cbad     = frame_start ? 1'b0 : checksum_bad;
    tbad     = frame_start ? 1'b0 : tail_bad;
    chk_pos  = {1'b0, len} + 9'd3;
    tbad_end = tbad || (frame_byte != TAIL_SECOND);

    byte_position_next = byte_position;
    length_seen_next   = length_seen;
    running_xor_next   = running_xor;
    checksum_bad_next  = checksum_bad;
    tail_bad_next      = tail_bad;
    discarding_next    = discarding;
    res.valid          = 1'b0;
    res.code           = ST_OK;
    res.len            = 8'd0;

    if (accept && (frame_start || !discarding)) begin
      length_seen_next   = len;
      running_xor_next   = rx;
      checksum_bad_next  = cbad;
      tail_bad_next      = tbad;
      discarding_next    = 1'b0;
      byte_position_next = pos + 9'd1;

      if (pos == 9'd0) begin
        if (frame_byte != HDR_FIRST) begin
          res.valid = 1'b1;
          res.code  = ST_HEADER;
        end
      end else if (pos == 9'd1) begin
        if (frame_byte != HDR_SECOND) begin
          res.valid = 1'b1;
          res.code  = ST_HEADER;
        end
      end else if (pos == 9'd2) begin
        length_seen_next = frame_byte;
        running_xor_next = frame_byte;
        if (frame_byte > max_len) begin
          res.valid = 1'b1;
          res.code  = ST_TAIL_LEN;
          res.len   = frame_byte;
        end
      end else if (pos < chk_pos) begin
        running_xor_next = rx ^ frame_byte;
      end else if (pos == chk_pos) begin
        checksum_bad_next = (frame_byte != rx);
      end else if (pos == chk_pos + 9'd1) begin
        tail_bad_next = (frame_byte != TAIL_FIRST);
      end else begin
        tail_bad_next = tbad_end;
        res.valid     = 1'b1;
        res.len       = len;
        if (tbad_end) begin
          res.code = ST_TAIL_LEN;
        end else if (cbad) begin
          res.code = ST_CHECK;
        end else begin
          res.code = ST_OK;
        end
      end

      if (res.valid) begin
        discarding_next    = 1'b1;
        byte_position_next = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      length_seen   <= 8'd0;
      running_xor   <= 8'd0;
      checksum_bad  <= 1'b0;
      tail_bad      <= 1'b0;
      discarding    <= 1'b1;
    end else begin
      byte_position <= byte_position_next;
      length_seen   <= length_seen_next;
      running_xor   <= running_xor_next;
      checksum_bad  <= checksum_bad_next;
      tail_bad      <= tail_bad_next;
      discarding    <= discarding_next;
    end
  end

  // every status closes the frame
  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> discarding)
    else $error("frame still open after status");

  // header errors never report a length
  a_hdr_len_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.code == ST_HEADER |-> res.len == 8'd0)
    else $error("header error with nonzero length");

  // position stays inside the longest frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !discarding |-> byte_position <= 9'd261)
    else $error("byte position out of range");

endmodule

@@ sv/framed_packet_xor_checker.sv @@
// Top level: framed packet checker with byte input, status output and APB register.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, frame_byte, frame_start  | input item
//  out     | out_valid, out_ready, status_code,           | result item
//          | payload_length                               |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata | APB slave
//
// One byte per cycle while in_ready is high; the status of a frame appears in the
// cycle after its closing byte (or failing header/length byte) is taken.
// in_ready drops only while a status is held and out_ready is low.
// Synchronous reset; after reset bytes are dropped until a start flag.
// max_payload_len resets to 252.
`timescale 1ns / 1ps
module framed_packet_xor_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 frame_byte,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status_code,
  output logic [7:0]                 payload_length,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpx_pkg::ADDR_W-1:0] paddr,
  input  logic [fpx_pkg::DATA_W-1:0] pwdata,
  output logic [fpx_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import fpx_pkg::*;

  logic [7:0] max_len;
  logic       in_acc;
  logic       reg_sel;
  result_t    res;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_MAX_PAYLOAD_LEN);
  assign prdata  = reg_sel ? {{(DATA_W-8){1'b0}}, max_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_len <= pwdata[7:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  fpx_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_acc),
    .frame_byte  (frame_byte),
    .frame_start (frame_start),
    .max_len     (max_len),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      status_code    <= res.code;
      payload_length <= res.len;
    end
  end

  // a new status only follows an accepted byte
  a_out_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("status without an accepted item");

  // a held status is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_acc)
    else $error("item accepted over a stalled status");

  // a stalled status keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status_code) && $stable(payload_length))
    else $error("stalled status changed");

endmodule
